/* rtl/ldpp_pkg.sv */
`default_nettype none

package ldpp_pkg;

  localparam logic [2:0] REG_FOCAL_X         = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y         = 3'd1;
  localparam logic [2:0] REG_PRINCIPAL_POINT = 3'd2;
  localparam logic [2:0] REG_AXIS_SKEW       = 3'd3;
  localparam logic [2:0] REG_RADIAL_K1       = 3'd4;
  localparam logic [2:0] REG_RADIAL_K2       = 3'd5;
  localparam logic [2:0] REG_RADIAL_K3       = 3'd6;
  localparam logic [2:0] REG_TANGENTIAL_PAIR = 3'd7;

  localparam logic [31:0] FOCAL_RESET = 32'd32768000;
  localparam logic signed [31:0] Q24_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q24_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q24_ONE = 32'sh0100_0000;

  typedef logic signed [31:0] q24_t;

  // Rounds half up at bit 24.
  function automatic logic signed [40:0] rnd24(input logic signed [64:0] p);
    logic signed [64:0] s;
    s = p + 65'sd8388608;
    return $signed(s[64:24]);
  endfunction

  function automatic q24_t sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return Q24_MAX;
    end else if (v < -48'sd2147483648) begin
      return Q24_MIN;
    end
    return v[31:0];
  endfunction

  function automatic q24_t mfin(input logic signed [63:0] p);
    return sat32(48'(rnd24(65'(p))));
  endfunction

endpackage

`default_nettype wire

/* rtl/lens_distort_pixel_point_top.sv */
`default_nettype none

// Channel  Direction  Ports                                         Transfer
// input    in         start, busy, in_pixel_x, in_pixel_y           start & !busy
// result   out        out_valid, out_distorted_x/_y, out_clipped    out_valid, one cycle
// config   in         cfg_we, cfg_index, cfg_data                   cfg_we
//
// A point may enter on every clock cycle.
// Most of the latency comes from the two pipelined dividers, one quotient bit per stage.
// busy is always low and the receiver cannot stall, so the pipeline never holds.
// Reset is synchronous and active low; it clears the valid chain and resets the config registers.

module lens_distort_pixel_point_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire        [15:0]  in_pixel_x,
  input  wire        [15:0]  in_pixel_y,
  output logic               out_valid,
  output logic signed [18:0] out_distorted_x,
  output logic signed [18:0] out_distorted_y,
  output logic               out_clipped,
  input  wire                cfg_we,
  input  wire        [2:0]   cfg_index,
  input  wire        [63:0]  cfg_data
);

  localparam int LAT = 87;

  logic [31:0] focal_x_r, focal_y_r, axis_skew_r, radial_k1_r, radial_k2_r, radial_k3_r;
  logic [63:0] principal_r, tangential_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r    <= ldpp_pkg::FOCAL_RESET;
      focal_y_r    <= ldpp_pkg::FOCAL_RESET;
      principal_r  <= '0;
      axis_skew_r  <= '0;
      radial_k1_r  <= '0;
      radial_k2_r  <= '0;
      radial_k3_r  <= '0;
      tangential_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldpp_pkg::REG_FOCAL_X:         focal_x_r    <= cfg_data[31:0];
        ldpp_pkg::REG_FOCAL_Y:         focal_y_r    <= cfg_data[31:0];
        ldpp_pkg::REG_PRINCIPAL_POINT: principal_r  <= cfg_data;
        ldpp_pkg::REG_AXIS_SKEW:       axis_skew_r  <= cfg_data[31:0];
        ldpp_pkg::REG_RADIAL_K1:       radial_k1_r  <= cfg_data[31:0];
        ldpp_pkg::REG_RADIAL_K2:       radial_k2_r  <= cfg_data[31:0];
        ldpp_pkg::REG_RADIAL_K3:       radial_k3_r  <= cfg_data[31:0];
        ldpp_pkg::REG_TANGENTIAL_PAIR: tangential_r <= cfg_data;
        default:                       focal_x_r    <= focal_x_r;
      endcase
    end
  end

  logic [31:0] cx, cy;
  ldpp_pkg::q24_t sk, k1, k2, k3, p1, p2;

  always_comb begin
    cx = principal_r[31:0];
    cy = principal_r[63:32];
    sk = $signed(axis_skew_r);
    k1 = $signed(radial_k1_r);
    k2 = $signed(radial_k2_r);
    k3 = $signed(radial_k3_r);
    p1 = $signed(tangential_r[31:0]);
    p2 = $signed(tangential_r[63:32]);
  end

  assign busy = 1'b0;

  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  logic signed [33:0] ny_r;
  logic        [15:0] px_r;

  always_ff @(posedge clk) begin
    ny_r <= $signed({6'b0, in_pixel_y, 12'b0}) - $signed({2'b0, cy});
    px_r <= in_pixel_x;
  end

  ldpp_pkg::q24_t y_w;
  logic [15:0] pxd_w;

  ldpp_div #(.NW(34), .SW(16)) u_div_y (
    .clk      (clk),
    .num      (ny_r),
    .den      (focal_y_r),
    .side     (px_r),
    .quo      (y_w),
    .side_out (pxd_w)
  );

  logic signed [63:0] sky_r;
  ldpp_pkg::q24_t y1_r, y2_r;
  logic [15:0] px1_r;
  logic signed [40:0] nx_r;

  always_ff @(posedge clk) begin
    sky_r <= sk * y_w;
    y1_r  <= y_w;
    px1_r <= pxd_w;
    nx_r  <= $signed({13'b0, px1_r, 12'b0}) - $signed({9'b0, cx})
             - ldpp_pkg::rnd24(65'(sky_r));
    y2_r  <= y1_r;
  end

  ldpp_pkg::q24_t x_w, yx_w;
  logic [31:0] yx_raw;

  ldpp_div #(.NW(41), .SW(32)) u_div_x (
    .clk      (clk),
    .num      (nx_r),
    .den      (focal_x_r),
    .side     (y2_r),
    .quo      (x_w),
    .side_out (yx_raw)
  );

  assign yx_w = $signed(yx_raw);

  logic signed [63:0] pxx_r, pyy_r, pxy_r;
  ldpp_pkg::q24_t xa_r, ya_r;
  ldpp_pkg::q24_t x2_r, y2b_r, xy_r, xb_r, yb_r;
  ldpp_pkg::q24_t xy2_r, r2_r, x2c_r, y2c_r, xc_r, yc_r;
  logic signed [63:0] pr4_r, pk1_r;
  ldpp_pkg::q24_t sx_r, sy_r, xy2d_r, r2d_r, xd_r0, yd_r0;
  ldpp_pkg::q24_t r4_r, m1e_r, r2e_r, xe_r, ye_r;
  logic signed [63:0] pt1_r, pt2_r, pt3_r, pt4_r;
  logic signed [63:0] pr6_r, pk2_r;
  ldpp_pkg::q24_t m1f_r, tx1f_r, tx2f_r, ty1f_r, ty2f_r, xf_r, yf_r;
  ldpp_pkg::q24_t r6_r, m2g_r, m1g_r, tx1g_r, tx2g_r, ty1g_r, ty2g_r, xg_r, yg_r;
  logic signed [63:0] pk3_r;
  ldpp_pkg::q24_t m1h_r, m2h_r, tx1h_r, tx2h_r, ty1h_r, ty2h_r, xh_r, yh_r;
  ldpp_pkg::q24_t m1i_r, m2i_r, m3i_r, tx1i_r, tx2i_r, ty1i_r, ty2i_r, xi_r, yi_r;
  ldpp_pkg::q24_t rr_r, tx1j_r, tx2j_r, ty1j_r, ty2j_r, xj_r, yj_r;
  logic signed [63:0] pxr_r, pyr_r;
  ldpp_pkg::q24_t tx1k_r, tx2k_r, ty1k_r, ty2k_r;
  ldpp_pkg::q24_t a_r, b_r, tx1l_r, tx2l_r, ty1l_r, ty2l_r;
  ldpp_pkg::q24_t xdm_r, ydm_r;
  logic signed [64:0] pu_r, pv_r;
  logic signed [63:0] ps_r;
  logic signed [42:0] u_r, v_r;

  always_ff @(posedge clk) begin
    pxx_r <= x_w * x_w;
    pyy_r <= yx_w * yx_w;
    pxy_r <= x_w * yx_w;
    xa_r  <= x_w;
    ya_r  <= yx_w;

    x2_r  <= ldpp_pkg::mfin(pxx_r);
    y2b_r <= ldpp_pkg::mfin(pyy_r);
    xy_r  <= ldpp_pkg::mfin(pxy_r);
    xb_r  <= xa_r;
    yb_r  <= ya_r;

    xy2_r <= ldpp_pkg::sat32(48'(xy_r) + 48'(xy_r));
    r2_r  <= ldpp_pkg::sat32(48'(x2_r) + 48'(y2b_r));
    x2c_r <= x2_r;
    y2c_r <= y2b_r;
    xc_r  <= xb_r;
    yc_r  <= yb_r;

    pr4_r  <= r2_r * r2_r;
    pk1_r  <= k1 * r2_r;
    sx_r   <= ldpp_pkg::sat32(48'(r2_r) + 48'(x2c_r) + 48'(x2c_r));
    sy_r   <= ldpp_pkg::sat32(48'(r2_r) + 48'(y2c_r) + 48'(y2c_r));
    xy2d_r <= xy2_r;
    r2d_r  <= r2_r;
    xd_r0  <= xc_r;
    yd_r0  <= yc_r;

    r4_r  <= ldpp_pkg::mfin(pr4_r);
    m1e_r <= ldpp_pkg::mfin(pk1_r);
    pt1_r <= p1 * xy2d_r;
    pt2_r <= p2 * sx_r;
    pt3_r <= p1 * sy_r;
    pt4_r <= p2 * xy2d_r;
    r2e_r <= r2d_r;
    xe_r  <= xd_r0;
    ye_r  <= yd_r0;

    pr6_r  <= r4_r * r2e_r;
    pk2_r  <= k2 * r4_r;
    m1f_r  <= m1e_r;
    tx1f_r <= ldpp_pkg::mfin(pt1_r);
    tx2f_r <= ldpp_pkg::mfin(pt2_r);
    ty1f_r <= ldpp_pkg::mfin(pt3_r);
    ty2f_r <= ldpp_pkg::mfin(pt4_r);
    xf_r   <= xe_r;
    yf_r   <= ye_r;

    r6_r   <= ldpp_pkg::mfin(pr6_r);
    m2g_r  <= ldpp_pkg::mfin(pk2_r);
    m1g_r  <= m1f_r;
    tx1g_r <= tx1f_r;
    tx2g_r <= tx2f_r;
    ty1g_r <= ty1f_r;
    ty2g_r <= ty2f_r;
    xg_r   <= xf_r;
    yg_r   <= yf_r;

    pk3_r  <= k3 * r6_r;
    m1h_r  <= m1g_r;
    m2h_r  <= m2g_r;
    tx1h_r <= tx1g_r;
    tx2h_r <= tx2g_r;
    ty1h_r <= ty1g_r;
    ty2h_r <= ty2g_r;
    xh_r   <= xg_r;
    yh_r   <= yg_r;

    m3i_r  <= ldpp_pkg::mfin(pk3_r);
    m1i_r  <= m1h_r;
    m2i_r  <= m2h_r;
    tx1i_r <= tx1h_r;
    tx2i_r <= tx2h_r;
    ty1i_r <= ty1h_r;
    ty2i_r <= ty2h_r;
    xi_r   <= xh_r;
    yi_r   <= yh_r;

    rr_r   <= ldpp_pkg::sat32(48'(ldpp_pkg::Q24_ONE) + 48'(m1i_r) + 48'(m2i_r)
                              + 48'(m3i_r));
    tx1j_r <= tx1i_r;
    tx2j_r <= tx2i_r;
    ty1j_r <= ty1i_r;
    ty2j_r <= ty2i_r;
    xj_r   <= xi_r;
    yj_r   <= yi_r;

    pxr_r  <= xj_r * rr_r;
    pyr_r  <= yj_r * rr_r;
    tx1k_r <= tx1j_r;
    tx2k_r <= tx2j_r;
    ty1k_r <= ty1j_r;
    ty2k_r <= ty2j_r;

    a_r    <= ldpp_pkg::mfin(pxr_r);
    b_r    <= ldpp_pkg::mfin(pyr_r);
    tx1l_r <= tx1k_r;
    tx2l_r <= tx2k_r;
    ty1l_r <= ty1k_r;
    ty2l_r <= ty2k_r;

    xdm_r <= ldpp_pkg::sat32(48'(a_r) + 48'(tx1l_r) + 48'(tx2l_r));
    ydm_r <= ldpp_pkg::sat32(48'(b_r) + 48'(ty1l_r) + 48'(ty2l_r));

    pu_r <= $signed({1'b0, focal_x_r}) * xdm_r;
    ps_r <= sk * ydm_r;
    pv_r <= $signed({1'b0, focal_y_r}) * ydm_r;

    u_r <= 43'(ldpp_pkg::rnd24(pu_r)) + 43'(ldpp_pkg::rnd24(65'(ps_r)))
           + $signed({11'b0, cx});
    v_r <= 43'(ldpp_pkg::rnd24(pv_r)) + $signed({11'b0, cy});
  end

  logic signed [42:0] su, sv;
  logic signed [30:0] tu, tv;
  logic signed [18:0] ox_nxt, oy_nxt;
  logic               clip_nxt;

  always_comb begin
    su       = u_r + 43'sd2048;
    sv       = v_r + 43'sd2048;
    tu       = $signed(su[42:12]);
    tv       = $signed(sv[42:12]);
    clip_nxt = 1'b0;
    if (tu > 31'sd262143) begin
      ox_nxt   = 19'sd262143;
      clip_nxt = 1'b1;
    end else if (tu < -31'sd262144) begin
      ox_nxt   = -19'sd262144;
      clip_nxt = 1'b1;
    end else begin
      ox_nxt = tu[18:0];
    end
    if (tv > 31'sd262143) begin
      oy_nxt   = 19'sd262143;
      clip_nxt = 1'b1;
    end else if (tv < -31'sd262144) begin
      oy_nxt   = -19'sd262144;
      clip_nxt = 1'b1;
    end else begin
      oy_nxt = tv[18:0];
    end
  end

  always_ff @(posedge clk) begin
    out_distorted_x <= ox_nxt;
    out_distorted_y <= oy_nxt;
    out_clipped     <= clip_nxt;
  end

  assign out_valid = vld_r[LAT-1];

endmodule

`default_nettype wire

/* rtl/ldpp_div.sv */
`default_nettype none

module ldpp_div #(
  parameter int NW = 34,
  parameter int SW = 16
) (
  input  wire                  clk,
  input  wire signed [NW-1:0]  num,
  input  wire        [31:0]    den,
  input  wire        [SW-1:0]  side,
  output logic signed [31:0]   quo,
  output logic       [SW-1:0]  side_out
);

  localparam int STEPS = 32;

  logic [32:0]   rem_r  [STEPS+1];
  logic [31:0]   quo_r  [STEPS+1];
  logic [31:0]   den_r  [STEPS+1];
  logic [7:0]    low_r  [STEPS+1];
  logic          neg_r  [STEPS+1];
  logic          ovf_r  [STEPS+1];
  logic [SW-1:0] side_r [STEPS+1];

  logic [NW-1:0] mag;
  logic [31:0]   den_n;
  logic [32:0]   rem0;

  always_comb begin
    mag   = num[NW-1] ? NW'(-num) : NW'(num);
    den_n = (den == 32'd0) ? 32'd1 : den;
    rem0  = 33'(mag >> 8);
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem0;
    quo_r[0]  <= '0;
    den_r[0]  <= den_n;
    low_r[0]  <= mag[7:0];
    neg_r[0]  <= num[NW-1];
    ovf_r[0]  <= rem0 >= {1'b0, den_n};
    side_r[0] <= side;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic        nbit;
    logic [32:0] cat;
    logic        ge;
    if (i < 8) begin : g_low
      assign nbit = low_r[i][7-i];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    assign cat = {rem_r[i][31:0], nbit};
    assign ge  = cat >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= ge ? cat - {1'b0, den_r[i]} : cat;
      quo_r[i+1]  <= {quo_r[i][30:0], ge};
      den_r[i+1]  <= den_r[i];
      low_r[i+1]  <= low_r[i];
      neg_r[i+1]  <= neg_r[i];
      ovf_r[i+1]  <= ovf_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  logic signed [31:0] quo_nxt;
  logic        [31:0] qm;

  always_comb begin
    qm = quo_r[STEPS];
    if (ovf_r[STEPS]) begin
      quo_nxt = neg_r[STEPS] ? ldpp_pkg::Q24_MIN : ldpp_pkg::Q24_MAX;
    end else if (!neg_r[STEPS]) begin
      quo_nxt = qm[31] ? ldpp_pkg::Q24_MAX : $signed(qm);
    end else begin
      quo_nxt = (qm > 32'h8000_0000) ? ldpp_pkg::Q24_MIN : $signed(-qm);
    end
  end

  always_ff @(posedge clk) begin
    quo      <= quo_nxt;
    side_out <= side_r[STEPS];
  end

endmodule

`default_nettype wire
